/* rtl/eeas_pkg.sv */
package eeas_pkg;

    // command codes carried in the operation field
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration port geometry
    localparam int CFG_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register indexes, byte address is 4 * index
    localparam logic [1:0] REG_SHIFT_HALF  = 2'd0;
    localparam logic [1:0] REG_LATCH       = 2'd1;
    localparam logic [1:0] REG_SETUP       = 2'd2;
    localparam logic [1:0] REG_WRITE_PULSE = 2'd3;

    // register reset values
    localparam int RST_SHIFT_HALF  = 3;
    localparam int RST_LATCH       = 2;
    localparam int RST_SETUP       = 1;
    localparam int RST_WRITE_PULSE = 4;

    // pin levels of the shift register and the memory
    typedef struct packed {
        logic ser;
        logic sclk;
        logic latch;
        logic ce_n;
        logic oe_n;
        logic we_n;
        logic drive;
    } t_pins;

endpackage

/* rtl/eeas_if.sv */
interface eeas_cmd_if #(
    parameter int ADDRESS_BITS = 16,
    parameter int DATA_BITS    = 8
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              operation;
    logic [ADDRESS_BITS-1:0] address;
    logic [DATA_BITS-1:0]    write_data;
    logic [DATA_BITS-1:0]    bus_in;

    modport source (output valid, output operation, output address,
                    output write_data, output bus_in, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, input bus_in, output ready);
endinterface

interface eeas_res_if #(
    parameter int DATA_BITS = 8
);
    logic                 valid;
    logic                 ready;
    logic                 shift_data;
    logic                 shift_clock;
    logic                 shift_latch;
    logic                 chip_enable_n;
    logic                 output_enable_n;
    logic                 write_enable_n;
    logic [DATA_BITS-1:0] bus_out;
    logic                 bus_drive;
    logic                 busy_res;
    logic [DATA_BITS-1:0] read_data;
    logic                 read_valid;
    logic                 rejected;

    modport source (output valid, output shift_data, output shift_clock,
                    output shift_latch, output chip_enable_n, output output_enable_n,
                    output write_enable_n, output bus_out, output bus_drive,
                    output busy_res, output read_data, output read_valid,
                    output rejected, input ready);
    modport sink   (input valid, input shift_data, input shift_clock,
                    input shift_latch, input chip_enable_n, input output_enable_n,
                    input write_enable_n, input bus_out, input bus_drive,
                    input busy_res, input read_data, input read_valid,
                    input rejected, output ready);
endinterface

/* rtl/parallel_eeprom_access_sequencer.sv */
// a beat accepted on the command channel waits in the input register, its result in the result register
// throughput: one command or tick beat per cycle while the result channel does not stall
// the result register frees while a new beat waits in the input register
// reset: synchronous active-low; sequencer idle, write enable high, other pins low,
// wait registers back to shift half 3, latch 2, setup 1, write pulse 4
module parallel_eeprom_access_sequencer #(
    parameter int ADDRESS_BITS = 16,
    parameter int DATA_BITS    = 8,
    parameter int WAIT_BITS    = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    eeas_cmd_if.sink                        i_cmd,
    eeas_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [eeas_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [eeas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [eeas_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);

    logic [WAIT_BITS-1:0]    w_shift_half;
    logic [WAIT_BITS-1:0]    w_latch;
    logic [WAIT_BITS-1:0]    w_setup;
    logic [WAIT_BITS-1:0]    w_write_pulse;

    logic                    r_in_valid;
    logic [1:0]              r_in_op;
    logic [ADDRESS_BITS-1:0] r_in_addr;
    logic [DATA_BITS-1:0]    r_in_wdata;
    logic [DATA_BITS-1:0]    r_in_bus;

    logic                    r_out_valid;
    eeas_pkg::t_pins         r_out_pins;
    logic [DATA_BITS-1:0]    r_out_held;
    logic                    r_out_busy;
    logic [DATA_BITS-1:0]    r_out_last_read;
    logic                    r_out_read_valid;
    logic                    r_out_rej;

    eeas_pkg::t_pins         w_pins;
    logic [DATA_BITS-1:0]    w_held;
    logic                    w_busy;
    logic [DATA_BITS-1:0]    w_last_read;
    logic                    w_read_valid;
    logic                    w_rej;
    logic                    w_step;
    logic                    w_in_take;

    eeas_cfg #(
        .WAIT_BITS(WAIT_BITS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_shift_half  (w_shift_half),
        .o_latch       (w_latch),
        .o_setup       (w_setup),
        .o_write_pulse (w_write_pulse)
    );

    // a beat moves on when the result register is free or being drained
    assign w_step    = r_in_valid && (!r_out_valid || o_res.ready);
    assign w_in_take = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready = !r_in_valid || w_step;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_cmd.ready) begin
            r_in_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_op    <= i_cmd.operation;
            r_in_addr  <= i_cmd.address;
            r_in_wdata <= i_cmd.write_data;
            r_in_bus   <= i_cmd.bus_in;
        end
    end

    eeas_core #(
        .ADDRESS_BITS(ADDRESS_BITS),
        .DATA_BITS   (DATA_BITS),
        .WAIT_BITS   (WAIT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_operation   (r_in_op),
        .i_address     (r_in_addr),
        .i_write_data  (r_in_wdata),
        .i_bus_in      (r_in_bus),
        .i_shift_half  (w_shift_half),
        .i_latch       (w_latch),
        .i_setup       (w_setup),
        .i_write_pulse (w_write_pulse),
        .o_pins        (w_pins),
        .o_held        (w_held),
        .o_busy        (w_busy),
        .o_last_read   (w_last_read),
        .o_read_valid  (w_read_valid),
        .o_rejected    (w_rej)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_pins       <= w_pins;
            r_out_held       <= w_held;
            r_out_busy       <= w_busy;
            r_out_last_read  <= w_last_read;
            r_out_read_valid <= w_read_valid;
            r_out_rej        <= w_rej;
        end
    end

    // result beat fields
    assign o_res.valid           = r_out_valid;
    assign o_res.shift_data      = r_out_pins.ser;
    assign o_res.shift_clock     = r_out_pins.sclk;
    assign o_res.shift_latch     = r_out_pins.latch;
    assign o_res.chip_enable_n   = r_out_pins.ce_n;
    assign o_res.output_enable_n = r_out_pins.oe_n;
    assign o_res.write_enable_n  = r_out_pins.we_n;
    assign o_res.bus_out         = r_out_pins.drive ? r_out_held : '0;
    assign o_res.bus_drive       = r_out_pins.drive;
    assign o_res.busy_res        = r_out_busy;
    assign o_res.read_data       = r_out_last_read;
    assign o_res.read_valid      = r_out_read_valid;
    assign o_res.rejected        = r_out_rej;

endmodule

/* rtl/eeas_cfg.sv */
module eeas_cfg #(
    parameter int WAIT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [eeas_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [eeas_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [eeas_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output logic [WAIT_BITS-1:0]              o_shift_half,
    output logic [WAIT_BITS-1:0]              o_latch,
    output logic [WAIT_BITS-1:0]              o_setup,
    output logic [WAIT_BITS-1:0]              o_write_pulse
);

    logic [WAIT_BITS-1:0] r_shift_half;
    logic [WAIT_BITS-1:0] r_latch;
    logic [WAIT_BITS-1:0] r_setup;
    logic [WAIT_BITS-1:0] r_write_pulse;
    logic [1:0]           w_index;
    logic                 w_write;
    logic [WAIT_BITS-1:0] w_rdata;

    assign pready  = 1'b1;
    assign w_index = paddr[3:2];
    assign w_write = psel && penable && pwrite;

    // register writes in the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_half  <= WAIT_BITS'(eeas_pkg::RST_SHIFT_HALF);
            r_latch       <= WAIT_BITS'(eeas_pkg::RST_LATCH);
            r_setup       <= WAIT_BITS'(eeas_pkg::RST_SETUP);
            r_write_pulse <= WAIT_BITS'(eeas_pkg::RST_WRITE_PULSE);
        end else if (w_write) begin
            case (w_index)
                eeas_pkg::REG_SHIFT_HALF:  r_shift_half  <= pwdata[WAIT_BITS-1:0];
                eeas_pkg::REG_LATCH:       r_latch       <= pwdata[WAIT_BITS-1:0];
                eeas_pkg::REG_SETUP:       r_setup       <= pwdata[WAIT_BITS-1:0];
                eeas_pkg::REG_WRITE_PULSE: r_write_pulse <= pwdata[WAIT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_index)
            eeas_pkg::REG_SHIFT_HALF:  w_rdata = r_shift_half;
            eeas_pkg::REG_LATCH:       w_rdata = r_latch;
            eeas_pkg::REG_SETUP:       w_rdata = r_setup;
            eeas_pkg::REG_WRITE_PULSE: w_rdata = r_write_pulse;
            default:                   w_rdata = '0;
        endcase
    end

    assign prdata = eeas_pkg::APB_DATA_W'(w_rdata);

    assign o_shift_half  = r_shift_half;
    assign o_latch       = r_latch;
    assign o_setup       = r_setup;
    assign o_write_pulse = r_write_pulse;

endmodule

/* rtl/eeas_core.sv */
module eeas_core #(
    parameter int ADDRESS_BITS = 16,
    parameter int DATA_BITS    = 8,
    parameter int WAIT_BITS    = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  logic [1:0]              i_operation,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  logic [DATA_BITS-1:0]    i_write_data,
    input  logic [DATA_BITS-1:0]    i_bus_in,
    input  logic [WAIT_BITS-1:0]    i_shift_half,
    input  logic [WAIT_BITS-1:0]    i_latch,
    input  logic [WAIT_BITS-1:0]    i_setup,
    input  logic [WAIT_BITS-1:0]    i_write_pulse,
    output eeas_pkg::t_pins         o_pins,
    output logic [DATA_BITS-1:0]    o_held,
    output logic                    o_busy,
    output logic [DATA_BITS-1:0]    o_last_read,
    output logic                    o_read_valid,
    output logic                    o_rejected
);

    localparam int CNT_W = $clog2(ADDRESS_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(ADDRESS_BITS - 1);

    // sequence phases
    localparam logic [2:0] PH_IDLE        = 3'd0;
    localparam logic [2:0] PH_ENABLE      = 3'd1;
    localparam logic [2:0] PH_CLK_LOW     = 3'd2;
    localparam logic [2:0] PH_CLK_HIGH    = 3'd3;
    localparam logic [2:0] PH_LATCH_WAIT  = 3'd4;
    localparam logic [2:0] PH_READ_SETTLE = 3'd5;
    localparam logic [2:0] PH_DATA_SETTLE = 3'd6;
    localparam logic [2:0] PH_WRITE_PULSE = 3'd7;

    logic [2:0]              r_phase,     n_phase;
    logic [CNT_W-1:0]        r_bit_cnt,   n_bit_cnt;
    logic [WAIT_BITS-1:0]    r_wait,      n_wait;
    logic [ADDRESS_BITS-1:0] r_shifter,   n_shifter;
    logic [DATA_BITS-1:0]    r_held,      n_held;
    logic                    r_doing_wr,  n_doing_wr;
    eeas_pkg::t_pins         r_pins,      n_pins;
    logic [DATA_BITS-1:0]    r_last_read, n_last_read;
    logic                    w_valid;
    logic                    w_rej;
    logic                    w_cmd;

    assign w_cmd = (i_operation == eeas_pkg::OP_READ) || (i_operation == eeas_pkg::OP_WRITE);

    // next state for one item
    always_comb begin
        n_phase     = r_phase;
        n_bit_cnt   = r_bit_cnt;
        n_wait      = r_wait;
        n_shifter   = r_shifter;
        n_held      = r_held;
        n_doing_wr  = r_doing_wr;
        n_pins      = r_pins;
        n_last_read = r_last_read;
        w_valid     = 1'b0;
        w_rej       = 1'b0;
        if (w_cmd) begin
            if (r_phase != PH_IDLE) begin
                w_rej = 1'b1;
            end else begin
                n_shifter = i_address;
                n_bit_cnt = '0;
                if (i_operation == eeas_pkg::OP_READ) begin
                    n_doing_wr  = 1'b0;
                    n_pins.ce_n = 1'b0;
                    n_pins.oe_n = 1'b0;
                    n_phase     = PH_ENABLE;
                    n_wait      = i_setup;
                end else begin
                    n_doing_wr   = 1'b1;
                    n_held       = i_write_data;
                    n_pins.latch = 1'b0;
                    n_pins.sclk  = 1'b0;
                    n_pins.ser   = i_address[ADDRESS_BITS-1];
                    n_phase      = PH_CLK_LOW;
                    n_wait       = i_shift_half;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_wait != '0) begin
                n_wait = r_wait - 1'b1;
            end else begin
                case (r_phase)
                    PH_ENABLE: begin
                        n_pins.latch = 1'b0;
                        n_pins.sclk  = 1'b0;
                        n_pins.ser   = r_shifter[ADDRESS_BITS-1];
                        n_phase      = PH_CLK_LOW;
                        n_wait       = i_shift_half;
                    end
                    PH_CLK_LOW: begin
                        n_pins.sclk = 1'b1;
                        n_phase     = PH_CLK_HIGH;
                        n_wait      = i_shift_half;
                    end
                    PH_CLK_HIGH: begin
                        // next bit comes from the shifted address msb
                        if (r_bit_cnt != LAST_BIT) begin
                            n_bit_cnt    = r_bit_cnt + 1'b1;
                            n_shifter    = {r_shifter[ADDRESS_BITS-2:0], 1'b0};
                            n_pins.latch = 1'b0;
                            n_pins.sclk  = 1'b0;
                            n_pins.ser   = r_shifter[ADDRESS_BITS-2];
                            n_phase      = PH_CLK_LOW;
                            n_wait       = i_shift_half;
                        end else begin
                            n_phase = PH_LATCH_WAIT;
                            n_wait  = i_latch;
                        end
                    end
                    PH_LATCH_WAIT: begin
                        n_pins.latch = 1'b1;
                        n_wait       = i_setup;
                        if (r_doing_wr) begin
                            n_pins.drive = 1'b1;
                            n_phase      = PH_DATA_SETTLE;
                        end else begin
                            n_phase = PH_READ_SETTLE;
                        end
                    end
                    PH_READ_SETTLE: begin
                        n_last_read = i_bus_in;
                        n_pins.ce_n = 1'b1;
                        n_pins.oe_n = 1'b1;
                        n_phase     = PH_IDLE;
                        n_wait      = '0;
                        w_valid     = 1'b1;
                    end
                    PH_DATA_SETTLE: begin
                        n_pins.oe_n = 1'b1;
                        n_pins.ce_n = 1'b0;
                        n_pins.we_n = 1'b0;
                        n_phase     = PH_WRITE_PULSE;
                        n_wait      = i_write_pulse;
                    end
                    PH_WRITE_PULSE: begin
                        n_pins.ce_n  = 1'b0;
                        n_pins.we_n  = 1'b1;
                        n_pins.drive = 1'b0;
                        n_phase      = PH_IDLE;
                        n_wait       = '0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_wait  = '0;
                    end
                endcase
            end
        end
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_cnt   <= '0;
            r_wait      <= '0;
            r_shifter   <= '0;
            r_held      <= '0;
            r_doing_wr  <= 1'b0;
            r_pins      <= '{ser: 1'b0, sclk: 1'b0, latch: 1'b0, ce_n: 1'b0,
                             oe_n: 1'b0, we_n: 1'b1, drive: 1'b0};
            r_last_read <= '0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_bit_cnt   <= n_bit_cnt;
            r_wait      <= n_wait;
            r_shifter   <= n_shifter;
            r_held      <= n_held;
            r_doing_wr  <= n_doing_wr;
            r_pins      <= n_pins;
            r_last_read <= n_last_read;
        end
    end

    // result reflects the state after the item
    assign o_pins       = n_pins;
    assign o_held       = n_held;
    assign o_busy       = (n_phase != PH_IDLE);
    assign o_last_read  = n_last_read;
    assign o_read_valid = w_valid;
    assign o_rejected   = w_rej;

endmodule

/* rtl/eeas_checker.sv */
module eeas_checker #(
    parameter int DATA_BITS = 8
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_valid,
    input logic                 i_ready,
    input logic [DATA_BITS-1:0] i_bus_out,
    input logic                 i_bus_drive,
    input logic                 i_busy,
    input logic                 i_read_valid,
    input logic                 i_rejected,
    input logic                 i_ce_n,
    input logic                 i_oe_n
);

    // a stalled result beat stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("result beat dropped while stalled");

    // a finished read leaves the block idle with both enables high
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_read_valid |-> !i_busy && i_ce_n && i_oe_n)
        else $error("read finished with sequence still active");

    // only a running sequence rejects commands
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_rejected |-> i_busy && !i_read_valid)
        else $error("command rejected while idle");

    // released bus carries zero
    a_bus_released: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_bus_drive |-> i_bus_out == '0)
        else $error("bus value shown while not driving");

endmodule

bind parallel_eeprom_access_sequencer eeas_checker #(
    .DATA_BITS(DATA_BITS)
) u_eeas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (o_res.valid),
    .i_ready      (o_res.ready),
    .i_bus_out    (o_res.bus_out),
    .i_bus_drive  (o_res.bus_drive),
    .i_busy       (o_res.busy_res),
    .i_read_valid (o_res.read_valid),
    .i_rejected   (o_res.rejected),
    .i_ce_n       (o_res.chip_enable_n),
    .i_oe_n       (o_res.output_enable_n)
);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int RANDOM_BEATS = 450;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2_000_000;
    localparam int MAX_REPORTS  = 10;

    // the spare operation code behaves as a tick
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef enum logic [3:0] {
        SEQ_IDLE,
        SEQ_ENABLE,
        SEQ_CLK_LOW,
        SEQ_CLK_HIGH,
        SEQ_LATCH_WAIT,
        SEQ_READ_SETTLE,
        SEQ_DATA_SETTLE,
        SEQ_WRITE_PULSE
    } t_seq_phase;

    typedef struct {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
        logic [DATA_W-1:0] bus;
        int                gap;
    } t_ee_beat;

    typedef struct packed {
        logic              shift_data;
        logic              shift_clock;
        logic              shift_latch;
        logic              ce_n;
        logic              oe_n;
        logic              we_n;
        logic [DATA_W-1:0] bus_out;
        logic              bus_drive;
        logic              busy;
        logic [DATA_W-1:0] read_data;
        logic              read_valid;
        logic              rejected;
    } t_pin_view;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [eeas_pkg::CFG_ADDR_W-1:0] paddr;
    logic [eeas_pkg::APB_DATA_W-1:0] pwdata;
    logic [eeas_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    eeas_cmd_if #(.ADDRESS_BITS(ADDR_W), .DATA_BITS(DATA_W)) cmd_ch ();
    eeas_res_if #(.DATA_BITS(DATA_W)) res_ch ();

    parallel_eeprom_access_sequencer #(
        .ADDRESS_BITS(ADDR_W),
        .DATA_BITS   (DATA_W),
        .WAIT_BITS   (16)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch),
        .o_res  (res_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // sequencer mirror: wait registers
    logic [15:0] half_cfg  = 16'(eeas_pkg::RST_SHIFT_HALF);
    logic [15:0] latch_cfg = 16'(eeas_pkg::RST_LATCH);
    logic [15:0] setup_cfg = 16'(eeas_pkg::RST_SETUP);
    logic [15:0] pulse_cfg = 16'(eeas_pkg::RST_WRITE_PULSE);

    // sequencer mirror: state after reset
    t_seq_phase        seq_phase   = SEQ_IDLE;
    logic [4:0]        bit_cnt     = '0;
    logic [15:0]       wait_cnt    = '0;
    logic [ADDR_W-1:0] addr_sr     = '0;
    logic [DATA_W-1:0] held_byte   = '0;
    logic              doing_write = 1'b0;
    logic [DATA_W-1:0] last_read   = '0;
    eeas_pkg::t_pins   pins        = '{we_n: 1'b1, default: 1'b0};

    t_ee_beat  pending_beats[$];
    t_pin_view expected_views[$];

    logic cmd_fired = 1'b0;
    logic res_fired = 1'b0;
    bit   tx_calm   = 1'b0;
    bit   rx_calm   = 1'b0;
    int   hold_starts = 0;
    int   beats_queued = 0;
    int   beats_checked = 0;
    int   reads_done = 0;
    int   refusals = 0;
    int   reg_writes = 0;
    int   mismatches = 0;
    int   cycle_count = 0;

    function automatic void enter_step(t_seq_phase nxt, logic [15:0] ticks);
        seq_phase = nxt;
        wait_cnt  = ticks;
    endfunction

    // present the next address bit, msb first, with the shift clock low
    function automatic void start_bit();
        pins.latch = 1'b0;
        pins.sclk  = 1'b0;
        pins.ser   = addr_sr[4'd15 - bit_cnt[3:0]];
        enter_step(SEQ_CLK_LOW, half_cfg);
    endfunction

    // one tick of time; returns 1 when a read completes
    function automatic logic advance_tick(logic [DATA_W-1:0] bus);
        if (seq_phase == SEQ_IDLE)
            return 1'b0;
        if (wait_cnt != 0) begin
            wait_cnt = wait_cnt - 1'b1;
            return 1'b0;
        end
        case (seq_phase)
            SEQ_ENABLE: start_bit();
            SEQ_CLK_LOW: begin
                pins.sclk = 1'b1;
                enter_step(SEQ_CLK_HIGH, half_cfg);
            end
            SEQ_CLK_HIGH: begin
                bit_cnt = bit_cnt + 1'b1;
                if (bit_cnt < 5'(ADDR_W))
                    start_bit();
                else
                    enter_step(SEQ_LATCH_WAIT, latch_cfg);
            end
            SEQ_LATCH_WAIT: begin
                pins.latch = 1'b1;
                if (doing_write) begin
                    pins.drive = 1'b1;
                    enter_step(SEQ_DATA_SETTLE, setup_cfg);
                end else begin
                    enter_step(SEQ_READ_SETTLE, setup_cfg);
                end
            end
            SEQ_READ_SETTLE: begin
                last_read = bus;
                pins.ce_n = 1'b1;
                pins.oe_n = 1'b1;
                enter_step(SEQ_IDLE, '0);
                return 1'b1;
            end
            SEQ_DATA_SETTLE: begin
                pins.oe_n = 1'b1;
                pins.ce_n = 1'b0;
                pins.we_n = 1'b0;
                enter_step(SEQ_WRITE_PULSE, pulse_cfg);
            end
            SEQ_WRITE_PULSE: begin
                pins.ce_n  = 1'b0;
                pins.we_n  = 1'b1;
                pins.drive = 1'b0;
                enter_step(SEQ_IDLE, '0);
            end
            default: enter_step(SEQ_IDLE, '0);
        endcase
        return 1'b0;
    endfunction

    // advance the mirror by one accepted beat and return the pins it should show
    function automatic t_pin_view apply_beat(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                             logic [DATA_W-1:0] wdata,
                                             logic [DATA_W-1:0] bus);
        t_pin_view v;
        logic      done;
        logic      refused;
        done    = 1'b0;
        refused = 1'b0;
        if (op == eeas_pkg::OP_READ || op == eeas_pkg::OP_WRITE) begin
            if (seq_phase != SEQ_IDLE) begin
                refused = 1'b1;
            end else begin
                addr_sr = addr;
                bit_cnt = '0;
                if (op == eeas_pkg::OP_READ) begin
                    doing_write = 1'b0;
                    pins.ce_n   = 1'b0;
                    pins.oe_n   = 1'b0;
                    enter_step(SEQ_ENABLE, setup_cfg);
                end else begin
                    doing_write = 1'b1;
                    held_byte   = wdata;
                    start_bit();
                end
            end
        end else begin
            done = advance_tick(bus);
        end
        v.shift_data  = pins.ser;
        v.shift_clock = pins.sclk;
        v.shift_latch = pins.latch;
        v.ce_n        = pins.ce_n;
        v.oe_n        = pins.oe_n;
        v.we_n        = pins.we_n;
        v.bus_out     = pins.drive ? held_byte : '0;
        v.bus_drive   = pins.drive;
        v.busy        = (seq_phase != SEQ_IDLE);
        v.read_data   = last_read;
        v.read_valid  = done;
        v.rejected    = refused;
        return v;
    endfunction

    function automatic string view_diff(t_pin_view e, t_pin_view g);
        string s;
        s = "";
        if (g.shift_data !== e.shift_data)   s = {s, " shift_data"};
        if (g.shift_clock !== e.shift_clock) s = {s, " shift_clock"};
        if (g.shift_latch !== e.shift_latch) s = {s, " shift_latch"};
        if (g.ce_n !== e.ce_n)               s = {s, " chip_enable_n"};
        if (g.oe_n !== e.oe_n)               s = {s, " output_enable_n"};
        if (g.we_n !== e.we_n)               s = {s, " write_enable_n"};
        if (g.bus_out !== e.bus_out)         s = {s, " bus_out"};
        if (g.bus_drive !== e.bus_drive)     s = {s, " bus_drive"};
        if (g.busy !== e.busy)               s = {s, " busy_res"};
        if (g.read_data !== e.read_data)     s = {s, " read_data"};
        if (g.read_valid !== e.read_valid)   s = {s, " read_valid"};
        if (g.rejected !== e.rejected)       s = {s, " rejected"};
        return s;
    endfunction

    // monitor: mirror every accepted command beat, check every accepted result beat
    always @(posedge i_clk) begin
        t_pin_view exp_v;
        t_pin_view got_v;
        string     diff;
        cmd_fired = i_rst_n && cmd_ch.valid && cmd_ch.ready;
        res_fired = i_rst_n && res_ch.valid && res_ch.ready;
        if (cmd_fired) begin
            exp_v = apply_beat(cmd_ch.operation, cmd_ch.address, cmd_ch.write_data,
                               cmd_ch.bus_in);
            reads_done += exp_v.read_valid;
            refusals   += exp_v.rejected;
            expected_views.push_back(exp_v);
        end
        if (res_fired) begin
            got_v.shift_data  = res_ch.shift_data;
            got_v.shift_clock = res_ch.shift_clock;
            got_v.shift_latch = res_ch.shift_latch;
            got_v.ce_n        = res_ch.chip_enable_n;
            got_v.oe_n        = res_ch.output_enable_n;
            got_v.we_n        = res_ch.write_enable_n;
            got_v.bus_out     = res_ch.bus_out;
            got_v.bus_drive   = res_ch.bus_drive;
            got_v.busy        = res_ch.busy_res;
            got_v.read_data   = res_ch.read_data;
            got_v.read_valid  = res_ch.read_valid;
            got_v.rejected    = res_ch.rejected;
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result beat %0d arrived with nothing pending: %h",
                             beats_checked, got_v);
            end else begin
                exp_v = expected_views.pop_front();
                diff  = view_diff(exp_v, got_v);
                if (diff != "") begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("result beat %0d wrong in%s: expected %h, got %h",
                                 beats_checked, diff, exp_v, got_v);
                end
            end
            beats_checked++;
        end
    end

    // command driver: honors the gap carried by each pending beat
    always @(negedge i_clk) begin
        t_ee_beat nxt;
        logic     offer;
        int       gap_waited;
        offer = cmd_ch.valid && !cmd_fired && i_rst_n;
        if (i_rst_n && !offer && pending_beats.size() != 0) begin
            if (gap_waited >= pending_beats[0].gap) begin
                nxt = pending_beats.pop_front();
                gap_waited = 0;
                offer = 1'b1;
                cmd_ch.operation  <= nxt.op;
                cmd_ch.address    <= nxt.addr;
                cmd_ch.write_data <= nxt.wdata;
                cmd_ch.bus_in     <= nxt.bus;
            end else begin
                gap_waited++;
            end
        end
        cmd_ch.valid <= offer;
    end

    // result receiver: random stall per beat, plus a long hold-off on request
    always @(negedge i_clk) begin
        logic take;
        int   stall_left;
        int   hold_left;
        int   hold_seen;
        if (hold_starts != hold_seen) begin
            hold_seen = hold_starts;
            hold_left = HOLD_CYCLES;
        end
        if (res_fired)
            stall_left = rx_calm ? 0 : $urandom_range(0, 5);
        if (!i_rst_n) begin
            take = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            take = 1'b0;
        end else if (stall_left != 0) begin
            stall_left--;
            take = 1'b0;
        end else begin
            take = 1'b1;
        end
        res_ch.ready <= take;
    end

    // run timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, expected_views.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic int draw_gap();
        return tx_calm ? 0 : $urandom_range(0, 5);
    endfunction

    function automatic void push_beat(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                      logic [DATA_W-1:0] wdata, logic [DATA_W-1:0] bus);
        t_ee_beat b;
        b.op    = op;
        b.addr  = addr;
        b.wdata = wdata;
        b.bus   = bus;
        b.gap   = draw_gap();
        pending_beats.push_back(b);
        beats_queued++;
    endfunction

    function automatic void push_tick(logic [DATA_W-1:0] bus);
        push_beat(($urandom_range(0, 7) == 0) ? OP_SPARE : eeas_pkg::OP_TICK,
                  ADDR_W'($urandom), DATA_W'($urandom), bus);
    endfunction

    // ticks a full sequence takes under the current wait registers
    function automatic int sequence_ticks(logic [1:0] op);
        int bits;
        bits = 2 * ADDR_W * (int'(half_cfg) + 1) + int'(latch_cfg) + 1;
        if (op == eeas_pkg::OP_READ)
            return bits + 2 * (int'(setup_cfg) + 1);
        return bits + int'(setup_cfg) + 1 + int'(pulse_cfg) + 1;
    endfunction

    // one start command followed by its ticks; noise adds refused commands,
    // a cut sequence stops early so the next start lands on a busy block
    function automatic void issue_sequence(logic [1:0] op, logic [ADDR_W-1:0] addr,
                                           logic [DATA_W-1:0] wdata, int bus_val,
                                           bit noisy, bit cut);
        int n;
        push_beat(op, addr, wdata, DATA_W'($urandom));
        n = sequence_ticks(op);
        if (cut)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++) begin
            if (noisy && $urandom_range(0, 15) == 0)
                push_beat($urandom_range(0, 1) ? eeas_pkg::OP_WRITE : eeas_pkg::OP_READ,
                          ADDR_W'($urandom), DATA_W'($urandom), DATA_W'($urandom));
            push_tick((bus_val < 0) ? DATA_W'($urandom) : DATA_W'(bus_val));
        end
        if (!cut)
            repeat ($urandom_range(0, 2)) push_tick(DATA_W'($urandom));
    endfunction

    task automatic drain_results();
        while (pending_beats.size() != 0 || cmd_ch.valid === 1'b1 ||
               expected_views.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // finish any open sequence so the next register write sees an idle block
    task automatic settle_sequencer();
        drain_results();
        while (seq_phase != SEQ_IDLE) begin
            repeat (int'(wait_cnt) + 1) push_tick(DATA_W'($urandom));
            drain_results();
        end
    endtask

    // two-phase register write
    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= eeas_pkg::CFG_ADDR_W'({idx, 2'b00});
        pwdata  <= eeas_pkg::APB_DATA_W'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        case (idx)
            eeas_pkg::REG_SHIFT_HALF: half_cfg  = val;
            eeas_pkg::REG_LATCH:      latch_cfg = val;
            eeas_pkg::REG_SETUP:      setup_cfg = val;
            default:                  pulse_cfg = val;
        endcase
        reg_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        int        random_start;
        logic [1:0] op;

        // known levels from time zero
        i_rst_n           = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.operation  = eeas_pkg::OP_TICK;
        cmd_ch.address    = '0;
        cmd_ch.write_data = '0;
        cmd_ch.bus_in     = '0;
        res_ch.ready      = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset wait values, idle ticks of both tick codes, full-scale read
        push_beat(eeas_pkg::OP_TICK, '1, '1, '1);
        push_beat(OP_SPARE, '0, '0, '0);
        issue_sequence(eeas_pkg::OP_READ, 16'hFFFF, 8'h00, 8'hFF, 1'b0, 1'b0);
        settle_sequencer();

        // zero waits: each step takes just its ending tick
        write_reg(eeas_pkg::REG_SHIFT_HALF, 16'd0);
        write_reg(eeas_pkg::REG_LATCH, 16'd0);
        write_reg(eeas_pkg::REG_SETUP, 16'd0);
        write_reg(eeas_pkg::REG_WRITE_PULSE, 16'd0);
        issue_sequence(eeas_pkg::OP_WRITE, 16'h0000, 8'hFF, -1, 1'b0, 1'b0);
        // one start on the idle block, then starts while busy are refused
        push_beat(eeas_pkg::OP_READ, 16'h0000, 8'h00, 8'h00);
        push_beat(eeas_pkg::OP_WRITE, 16'h1234, 8'h56, 8'h00);
        push_beat(eeas_pkg::OP_READ, 16'hFFFF, 8'hFF, 8'hFF);
        issue_sequence(eeas_pkg::OP_READ, 16'hAAAA, 8'h00, 8'h00, 1'b1, 1'b0);
        issue_sequence(eeas_pkg::OP_WRITE, 16'hFFFF, 8'h00, -1, 1'b0, 1'b0);
        settle_sequencer();

        // long receiver hold-off while the sender keeps offering beats
        tx_calm = 1'b1;
        hold_starts++;
        issue_sequence(eeas_pkg::OP_READ, ADDR_W'($urandom), '0, -1, 1'b0, 1'b0);
        settle_sequencer();

        // long waits on latch, setup, write pulse and shift half, back to back beats
        rx_calm = 1'b1;
        write_reg(eeas_pkg::REG_LATCH, 16'd40);
        write_reg(eeas_pkg::REG_SETUP, 16'd40);
        write_reg(eeas_pkg::REG_WRITE_PULSE, 16'd40);
        issue_sequence(eeas_pkg::OP_WRITE, ADDR_W'($urandom), DATA_W'($urandom), -1,
                       1'b0, 1'b0);
        settle_sequencer();
        write_reg(eeas_pkg::REG_SHIFT_HALF, 16'hFFFF);
        repeat (8) push_tick(DATA_W'($urandom));
        settle_sequencer();
        write_reg(eeas_pkg::REG_SHIFT_HALF, 16'd0);
        write_reg(eeas_pkg::REG_LATCH, 16'd1);
        write_reg(eeas_pkg::REG_SETUP, 16'd0);
        write_reg(eeas_pkg::REG_WRITE_PULSE, 16'd2);

        // random phases of mostly well formed sequences with small waits
        random_start = beats_queued;
        while (beats_queued - random_start < RANDOM_BEATS) begin
            if ($urandom_range(0, 1))
                write_reg(eeas_pkg::REG_SHIFT_HALF, ($urandom_range(0, 7) == 0) ? 16'd3 :
                          16'($urandom_range(0, 1)));
            if ($urandom_range(0, 1))
                write_reg(eeas_pkg::REG_LATCH, 16'($urandom_range(0, 4)));
            if ($urandom_range(0, 1))
                write_reg(eeas_pkg::REG_SETUP, 16'($urandom_range(0, 3)));
            if ($urandom_range(0, 1))
                write_reg(eeas_pkg::REG_WRITE_PULSE, 16'($urandom_range(0, 6)));
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(1, 3)) begin
                op = $urandom_range(0, 1) ? eeas_pkg::OP_WRITE : eeas_pkg::OP_READ;
                issue_sequence(op, ADDR_W'($urandom), DATA_W'($urandom), -1,
                               $urandom_range(0, 2) == 0, $urandom_range(0, 5) == 0);
            end
            settle_sequencer();
        end

        drain_results();
        $display("checked %0d result beats: %0d reads finished, %0d starts refused while busy",
                 beats_checked, reads_done, refusals);
        $display("%0d wait register writes, values from 0 to 65535; %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0 && expected_views.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
